// ===== hw/rtl/hsfd_pkg.sv =====
// shared types, codes and constants of the sample filter and window detector
`default_nettype none
package hsfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 9;
  localparam int IDX_W     = 8;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int SUM_W     = 22;

  localparam int HISTORY_DEPTH_DEF  = 256;
  localparam int BASELINE_COUNT_DEF = 64;

  localparam logic [GAIN_W-1:0] GAIN_ONE       = 9'd256;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 9'd26;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 16'd100;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_RECAL,
    OP_READ,
    OP_IDLE
  } hsfd_op_t;

  typedef struct packed {
    hsfd_op_t            op;
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    read_index;
  } hsfd_item_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } hsfd_bk_state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
  } hsfd_div_req_t;

  typedef struct packed {
    logic                busy;
    logic [SAMPLE_W-1:0] quotient;
  } hsfd_div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hsfd_front.sv =====
// front end: accepts items, decodes the kind and queues them for the back end
`default_nettype none
module hsfd_front import hsfd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [IDX_W-1:0]    in_read_index,
  output logic                     q_valid,
  output hsfd_item_t               q_item,
  input  wire logic                q_pop
);

  hsfd_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  hsfd_item_t dec_item;

  always_comb begin
    dec_item.sample     = in_sample;
    dec_item.read_index = in_read_index;
    unique case (in_kind)
      KIND_SAMPLE: dec_item.op = OP_SAMPLE;
      KIND_RECAL:  dec_item.op = OP_RECAL;
      KIND_READ:   dec_item.op = OP_READ;
      default:     dec_item.op = OP_IDLE;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hsfd_div.sv =====
// baseline mean: division by a constant through a reciprocal multiply
`default_nettype none
module hsfd_div import hsfd_pkg::*; #(
  parameter int DIVISOR = BASELINE_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hsfd_div_req_t req,
  output hsfd_div_rsp_t      rsp
);

  // n * ceil(2^(SUM_W+SH) / d) >> (SUM_W+SH) gives floor(n / d) for any SUM_W-bit n
  localparam int SH = $clog2(DIVISOR);
  localparam int MW = SUM_W + 1;
  localparam int PW = SUM_W + MW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << (SUM_W + SH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic [SUM_W-1:0]    dvd_r, dvd_nxt;
  logic                pend_r, pend_nxt;
  logic [SAMPLE_W-1:0] quo_r, quo_nxt;
  logic [PW-1:0]       prod;

  assign prod = {{MW{1'b0}}, dvd_r} * {{SUM_W{1'b0}}, RECIP};

  // cycle after start: multiply and register, cycle after that: quotient ready
  always_comb begin
    dvd_nxt  = req.start ? req.dividend : dvd_r;
    pend_nxt = req.start;
    quo_nxt  = pend_r ? prod[SUM_W+SH +: SAMPLE_W] : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvd_r  <= '0;
      pend_r <= 1'b0;
      quo_r  <= '0;
    end else begin
      dvd_r  <= dvd_nxt;
      pend_r <= pend_nxt;
      quo_r  <= quo_nxt;
    end
  end

  assign rsp.busy     = pend_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/hsfd_back.sv =====
// back end: filter update, history store, window logic and result register
`default_nettype none
module hsfd_back import hsfd_pkg::*; #(
  parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
  parameter int BASELINE_COUNT = BASELINE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [GAIN_W-1:0]   filter_gain,
  input  wire logic [SAMPLE_W-1:0] window_offset,
  input  wire logic                q_valid,
  input  wire hsfd_item_t          q_item,
  output logic                     q_pop,
  output hsfd_div_req_t            div_req,
  input  wire hsfd_div_rsp_t       div_rsp,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_filtered,
  output logic                     out_detected,
  output logic                     out_calibrated,
  output logic                     out_primed,
  output logic [IDX_W-1:0]         out_write_position,
  output logic [SAMPLE_W-1:0]      out_history_value
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  function automatic logic [SAMPLE_W-1:0] win_hi(input logic [SAMPLE_W-1:0] c,
                                                 input logic [SAMPLE_W-1:0] off);
    logic [SAMPLE_W:0] up;
    up = {1'b0, c} + {1'b0, off};
    return up[SAMPLE_W] ? '1 : up[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] win_lo(input logic [SAMPLE_W-1:0] c,
                                                 input logic [SAMPLE_W-1:0] off);
    return (c >= off) ? c - off : '0;
  endfunction

  hsfd_bk_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic                seeded_r, seeded_nxt;
  logic                window_set_r, window_set_nxt;
  logic                alarm_r, alarm_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [SAMPLE_W-1:0] up_r, up_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                hv_sel_r, hv_sel_nxt;
  logic [SAMPLE_W-1:0] hist_rd_r;

  logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];

  logic                out_free;
  logic                fire;
  logic                mem_we;
  logic                rd_en;
  logic [GAIN_W-1:0]   gain_sat;
  logic signed [26:0]  ema_prod;
  logic signed [26:0]  ema_sum;
  logic [SAMPLE_W-1:0] ema_val;
  logic [SAMPLE_W-1:0] new_avg;
  logic [AW-1:0]       slot_inc;
  logic [IW-1:0]       rd_ext;
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;

  // avg + floor((sample - avg) * g / 256) equals the weighted form exactly
  assign gain_sat = (filter_gain > GAIN_ONE) ? GAIN_ONE : filter_gain;
  assign ema_prod = ($signed({1'b0, q_item.sample}) - $signed({1'b0, avg_r}))
                    * $signed({1'b0, gain_sat});
  assign ema_sum  = $signed({11'd0, avg_r}) + (ema_prod >>> 8);
  assign ema_val  = ema_sum[SAMPLE_W-1:0];
  assign new_avg  = seeded_r ? ema_val : q_item.sample;

  assign slot_inc = (slot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + AW'(1);

  assign rd_ext      = IW'(q_item.read_index);
  assign rd_addr     = rd_ext[AW-1:0];
  assign rd_in_range = ({1'b0, rd_ext} < (IW+1)'(HISTORY_DEPTH));

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    fire           = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    div_req        = '0;
    avg_nxt        = avg_r;
    seeded_nxt     = seeded_r;
    window_set_nxt = window_set_r;
    alarm_nxt      = alarm_r;
    slot_nxt       = slot_r;
    up_nxt         = up_r;
    lo_nxt         = lo_r;
    sum_nxt        = sum_r;
    hv_sel_nxt     = hv_sel_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      BK_RUN: begin
        if (q_valid && out_free) begin
          fire          = 1'b1;
          out_valid_nxt = 1'b1;
          hv_sel_nxt    = 1'b0;
          case (q_item.op)
            OP_SAMPLE: begin
              avg_nxt    = new_avg;
              seeded_nxt = 1'b1;
              mem_we     = 1'b1;
              slot_nxt   = slot_inc;
              if (!window_set_r && (slot_r < AW'(BASELINE_COUNT))) begin
                sum_nxt = sum_r + SUM_W'(new_avg);
              end
              if (!window_set_r && (slot_inc == AW'(BASELINE_COUNT))) begin
                // baseline complete: hold the result until the mean is ready
                window_set_nxt   = 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = sum_nxt;
                out_valid_nxt    = 1'b0;
                state_nxt        = BK_DIV;
              end else begin
                alarm_nxt = window_set_r && ((new_avg > up_r) || (new_avg < lo_r));
              end
            end
            OP_RECAL: begin
              if (!alarm_r && seeded_r) begin
                up_nxt = win_hi(avg_r, window_offset);
                lo_nxt = win_lo(avg_r, window_offset);
              end
            end
            OP_READ: begin
              rd_en      = rd_in_range;
              hv_sel_nxt = rd_in_range;
            end
            default: ;
          endcase
        end
      end
      BK_DIV: begin
        if (!div_rsp.busy && out_free) begin
          up_nxt        = win_hi(div_rsp.quotient, window_offset);
          lo_nxt        = win_lo(div_rsp.quotient, window_offset);
          alarm_nxt     = (avg_r > up_nxt) || (avg_r < lo_nxt);
          hv_sel_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  assign q_pop = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r        <= '0;
      seeded_r     <= 1'b0;
      window_set_r <= 1'b0;
      alarm_r      <= 1'b0;
      slot_r       <= '0;
      up_r         <= '0;
      lo_r         <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      hv_sel_r     <= 1'b0;
    end else begin
      avg_r        <= avg_nxt;
      seeded_r     <= seeded_nxt;
      window_set_r <= window_set_nxt;
      alarm_r      <= alarm_nxt;
      slot_r       <= slot_nxt;
      up_r         <= up_nxt;
      lo_r         <= lo_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
      hv_sel_r     <= hv_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[slot_r] <= new_avg;
    end
    if (rd_en) begin
      hist_rd_r <= hist_mem[rd_addr];
    end
  end

  // status registers hold while a result waits, since nothing executes then
  assign out_valid          = out_valid_r;
  assign out_filtered       = avg_r;
  assign out_detected       = alarm_r;
  assign out_calibrated     = window_set_r;
  assign out_primed         = seeded_r;
  assign out_write_position = IDX_W'(slot_r);
  assign out_history_value  = hv_sel_r ? hist_rd_r : '0;

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= up_r)
    else $error("window lower bound above upper bound");

  a_alarm_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |-> window_set_r)
    else $error("detection raised before calibration");

  a_calib_waits_mean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(window_set_r) |-> (state_r == BK_DIV) && !out_valid_r)
    else $error("calibration result released before baseline mean");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= AW'(HISTORY_DEPTH - 1))
    else $error("history slot beyond depth");

endmodule
`default_nettype wire

// ===== hw/rtl/hall_sample_filter_detector_unit.sv =====
// Sample filter with baseline window detector, one result per input item.
// Input channel (in_valid/in_ready): in_kind selects a sample, a window
// recalibration or a history read; in_sample and in_read_index carry data.
// Result channel (out_valid/out_ready): filtered average, detected,
// calibrated, primed, write_position and the history entry that was read.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 filter gain in
// 1/256 units, index 1 window half width; write only while idle.
// Throughput: one item per cycle while out_ready is high. An item transferred
// is written into the queue; the back end takes it from there and registers
// its result. The single exception is the sample that completes the
// baseline: its mean comes from a reciprocal multiply with a dividend and
// a quotient register, which holds the back end once after reset.
// A two-entry queue sits between the front end and the back end, so input
// transfers continue while a result waits; when out_ready stays low the
// result holds and the queue fills, then in_ready drops.
// Reset (rst_n, synchronous) clears filter, window, slot and baseline state
// and restores the register defaults; the history store is not cleared.
`default_nettype none
module hall_sample_filter_detector_unit import hsfd_pkg::*; #(
  parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
  parameter int BASELINE_COUNT = BASELINE_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic [IDX_W-1:0]     in_read_index,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SAMPLE_W-1:0]       out_filtered,
  output logic                      out_detected,
  output logic                      out_calibrated,
  output logic                      out_primed,
  output logic [IDX_W-1:0]          out_write_position,
  output logic [SAMPLE_W-1:0]       out_history_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [SAMPLE_W-1:0] offset_r, offset_nxt;

  logic          q_valid;
  hsfd_item_t    q_item;
  logic          q_pop;
  hsfd_div_req_t div_req;
  hsfd_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    gain_nxt   = gain_r;
    offset_nxt = offset_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FILTER_GAIN:   gain_nxt   = cfg_wdata[GAIN_W-1:0];
        CFG_WINDOW_OFFSET: offset_nxt = cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= OFFSET_RESET;
    end else begin
      gain_r   <= gain_nxt;
      offset_r <= offset_nxt;
    end
  end

  hsfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_sample     (in_sample),
    .in_read_index (in_read_index),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  hsfd_div #(
    .DIVISOR (BASELINE_COUNT)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hsfd_back #(
    .HISTORY_DEPTH  (HISTORY_DEPTH),
    .BASELINE_COUNT (BASELINE_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .filter_gain        (gain_r),
    .window_offset      (offset_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered       (out_filtered),
    .out_detected       (out_detected),
    .out_calibrated     (out_calibrated),
    .out_primed         (out_primed),
    .out_write_position (out_write_position),
    .out_history_value  (out_history_value)
  );

endmodule
`default_nettype wire

// ===== bench/hall_sample_filter_detector_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the sample filter and window detector unit
module hall_sample_filter_detector_unit_test;
  import hsfd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                detected;
    logic                calibrated;
    logic                primed;
    logic [IDX_W-1:0]    write_position;
    logic [SAMPLE_W-1:0] history_value;
  } status_t;

  class filter_status_tracker;
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] half_width;
    logic [SAMPLE_W-1:0] average;
    bit                  seeded;
    bit                  calibrated;
    bit                  alarm;
    int                  slot;
    int                  filled;
    logic [SAMPLE_W-1:0] history [HISTORY_DEPTH_DEF];
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] lower;
    logic [SUM_W-1:0]    baseline_sum;
    status_t             expected_status [$];
    int                  error_count;

    function new();
      gain         = GAIN_RESET;
      half_width   = OFFSET_RESET;
      average      = '0;
      seeded       = 1'b0;
      calibrated   = 1'b0;
      alarm        = 1'b0;
      slot         = 0;
      filled       = 0;
      upper        = '0;
      lower        = '0;
      baseline_sum = '0;
      error_count  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      if (index == CFG_FILTER_GAIN) begin
        gain = data[GAIN_W-1:0];
      end else if (index == CFG_WINDOW_OFFSET) begin
        half_width = data;
      end
    endfunction

    // top saturates, bottom clamps at zero
    function void recenter(logic [SAMPLE_W-1:0] center);
      int unsigned top;
      top   = 32'(center) + 32'(half_width);
      upper = (top > 32'hFFFF) ? 16'hFFFF : top[SAMPLE_W-1:0];
      lower = (center >= half_width) ? center - half_width : '0;
    endfunction

    function void take_item(hsfd_op_t op, logic [SAMPLE_W-1:0] value,
                            logic [IDX_W-1:0] index);
      int unsigned weight;
      int unsigned mix;
      status_t     want;
      want.history_value = '0;
      case (op)
        OP_SAMPLE: begin
          if (!seeded) begin
            average = value;
            seeded  = 1'b1;
          end else begin
            weight  = (gain > GAIN_ONE) ? 32'(GAIN_ONE) : 32'(gain);
            mix     = (32'(average) * (32'd256 - weight) + 32'(value) * weight) >> 8;
            average = mix[SAMPLE_W-1:0];
          end
          history[slot] = average;
          if (filled < HISTORY_DEPTH_DEF) filled++;
          if (!calibrated && slot < BASELINE_COUNT_DEF) begin
            baseline_sum = baseline_sum + SUM_W'(average);
          end
          slot = (slot == HISTORY_DEPTH_DEF - 1) ? 0 : slot + 1;
          if (!calibrated && slot == BASELINE_COUNT_DEF) begin
            calibrated = 1'b1;
            recenter(SAMPLE_W'(baseline_sum / BASELINE_COUNT_DEF));
          end
          alarm = calibrated && (average > upper || average < lower);
        end
        // window moves only while nothing is detected; flag waits for next sample
        OP_RECAL: begin
          if (!alarm && seeded) recenter(average);
        end
        OP_READ: begin
          want.history_value = history[index];
        end
        default: ;
      endcase
      want.filtered       = average;
      want.detected       = alarm;
      want.calibrated     = calibrated;
      want.primed         = seeded;
      want.write_position = slot[IDX_W-1:0];
      expected_status.push_back(want);
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= 200) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("result with nothing pending, filtered %0d", got.filtered));
        return;
      end
      want = expected_status.pop_front();
      if (got.filtered !== want.filtered)
        report($sformatf("filtered %0d, want %0d", got.filtered, want.filtered));
      if (got.detected !== want.detected)
        report($sformatf("detected %0b, want %0b", got.detected, want.detected));
      if (got.calibrated !== want.calibrated)
        report($sformatf("calibrated %0b, want %0b", got.calibrated, want.calibrated));
      if (got.primed !== want.primed)
        report($sformatf("primed %0b, want %0b", got.primed, want.primed));
      if (got.write_position !== want.write_position)
        report($sformatf("write_position %0d, want %0d", got.write_position,
                         want.write_position));
      if (got.history_value !== want.history_value)
        report($sformatf("history_value %0d, want %0d", got.history_value,
                         want.history_value));
    endtask

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind       = '0;
  logic [SAMPLE_W-1:0]  in_sample     = '0;
  logic [IDX_W-1:0]     in_read_index = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [SAMPLE_W-1:0]  out_filtered;
  logic                 out_detected;
  logic                 out_calibrated;
  logic                 out_primed;
  logic [IDX_W-1:0]     out_write_position;
  logic [SAMPLE_W-1:0]  out_history_value;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_wdata     = '0;

  filter_status_tracker status_board;
  bit                   sender_burst   = 1'b0;
  bit                   receiver_burst = 1'b0;
  bit                   hold_off_req   = 1'b0;
  logic [SAMPLE_W-1:0]  level          = 16'h8000;
  int                   spread         = 200;
  int                   quiet_cycles   = 0;

  hall_sample_filter_detector_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_sample          (in_sample),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered       (out_filtered),
    .out_detected       (out_detected),
    .out_calibrated     (out_calibrated),
    .out_primed         (out_primed),
    .out_write_position (out_write_position),
    .out_history_value  (out_history_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(hsfd_op_t op, logic [SAMPLE_W-1:0] value,
                           logic [IDX_W-1:0] index);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= op;
    in_sample     <= value;
    in_read_index <= index;
    do @(posedge clk); while (!in_ready);
    status_board.take_item(op, value, index);
    @(negedge clk);
  endtask

  // samples mostly wander around a level so the average crosses window edges
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 4) return 16'hFFFF;
    if (pick < 8) return 16'h0000;
    if (pick < 16) return SAMPLE_W'($urandom_range(0, 65535));
    if (pick < 22) level = SAMPLE_W'($urandom_range(0, 65535));
    v = int'(level) - spread;
    v = v + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 58 || status_board.filled == 0) begin
        send_item(OP_SAMPLE, next_sample(), IDX_W'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        send_item(OP_RECAL, SAMPLE_W'($urandom_range(0, 65535)),
                  IDX_W'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        // only slots already written since reset are read
        send_item(OP_READ, SAMPLE_W'($urandom_range(0, 65535)),
                  IDX_W'($urandom_range(0, status_board.filled - 1)));
      end else begin
        send_item(OP_IDLE, SAMPLE_W'($urandom_range(0, 65535)),
                  IDX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    status_board.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] gain_plan [PHASES];
    logic [CFG_W-1:0] offset_plan [PHASES];
    status_board = new();
    gain_plan    = '{16'd0, 16'd256, 16'hFFFF, 16'd1, 16'd64, 16'd0};
    offset_plan  = '{16'd0, 16'd500, 16'hFFFF, 16'd2000, 16'd255, 16'd0};
    gain_plan[PHASES-1]   = CFG_W'($urandom_range(2, 255));
    offset_plan[PHASES-1] = CFG_W'($urandom_range(1, 4000));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items at the register defaults
    send_item(OP_IDLE,   16'hFFFF, 8'hFF);
    send_item(OP_RECAL,  16'h1234, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFF, 8'h00);
    send_item(OP_RECAL,  16'h0000, 8'h00);
    send_item(OP_READ,   16'h0000, 8'd0);
    send_item(OP_SAMPLE, 16'h0000, 8'hFF);
    send_item(OP_SAMPLE, 16'h0000, 8'h00);
    send_item(OP_SAMPLE, 16'hFFFF, 8'h00);
    send_item(OP_SAMPLE, 16'h8000, 8'h00);
    send_item(OP_SAMPLE, 16'h7FFF, 8'h00);
    send_item(OP_READ,   16'h0000, 8'd4);
    send_item(OP_READ,   16'hFFFF, 8'd0);
    send_item(OP_RECAL,  16'h0000, 8'h00);
    send_item(OP_IDLE,   16'h0000, 8'h00);
    send_item(OP_SAMPLE, 16'h0001, 8'h00);
    send_item(OP_READ,   16'h0000, 8'd5);

    // baseline fills during this stretch
    send_random(150);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_FILTER_GAIN, gain_plan[p]);
      write_reg(CFG_WINDOW_OFFSET, offset_plan[p]);
      spread = $urandom_range(0, 600);
      if (p == 4) begin
        send_random(50);
        hold_off_req = 1'b1;
        send_random(115);
      end else begin
        send_random(165);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (status_board.error_count == 0) begin
      $display("hall_sample_filter_detector_unit regression: pass");
    end else begin
      $display("hall_sample_filter_detector_unit regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int      gap;
    status_t got;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
      gap = receiver_burst ? 0 : $urandom_range(0, 19);
      // long hold-off lets the queue fill and back up the input side
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{filtered: out_filtered, detected: out_detected,
              calibrated: out_calibrated, primed: out_primed,
              write_position: out_write_position, history_value: out_history_value};
      status_board.check_result(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hall_sample_filter_detector_unit regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_front.sv
hw/rtl/hsfd_div.sv
hw/rtl/hsfd_back.sv
hw/rtl/hall_sample_filter_detector_unit.sv
bench/hall_sample_filter_detector_unit_test.sv
